FILE: sv/rvr_pkg.sv
// ----------------------------------------------------------------------------
// rvr_pkg
// Types and codes shared by the reader version ring cells, head unit and top.
// ----------------------------------------------------------------------------
package rvr_pkg;

	localparam int VER_W = 64;
	localparam int CNT_W = 32;
	localparam int OCC_W = 5;

	localparam logic [1:0] OP_ACQUIRE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [VER_W-1:0] version;
		logic [CNT_W-1:0] count;
	} entry_t;

	// what the head unit drives into the chain: shift for every cell, feed at the far end
	typedef struct packed {
		logic   shift;
		entry_t feed;
	} chain_ctrl_t;

endpackage

FILE: sv/rvr_cell.sv
// ----------------------------------------------------------------------------
// rvr_cell
// One ring slot: holds a version entry and hands it on to its neighbour on
// every shift.
// ----------------------------------------------------------------------------
module rvr_cell (
	input  logic           clk,
	input  logic           shift,
	input  rvr_pkg::entry_t d,
	output rvr_pkg::entry_t q
);

	rvr_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

FILE: sv/rvr_head.sv
// ----------------------------------------------------------------------------
// rvr_head
// Sequencer at the head of the cell chain. Rotates the ring past cell 0,
// updating, appending or popping entries as they go by, and forms results.
// ----------------------------------------------------------------------------
module rvr_head #(
	parameter int RING_DEPTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  opcode,
	input  logic [rvr_pkg::VER_W-1:0]   version,
	input  rvr_pkg::entry_t             head_entry,
	output logic                        busy,
	output rvr_pkg::chain_ctrl_t        ctrl,
	output logic                        done,
	output logic [rvr_pkg::VER_W-1:0]   oldest_version,
	output logic [1:0]                  status,
	output logic [rvr_pkg::OCC_W-1:0]   occupancy
);

	localparam int IW = $clog2(RING_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]                state_q;
	logic [1:0]                op_q;
	logic [rvr_pkg::VER_W-1:0] ver_q;
	logic [IW-1:0]             step_q;
	logic [IW-1:0]             occ_q;
	logic                      found_q;
	logic                      app_q;
	logic                      done_q;
	logic [rvr_pkg::VER_W-1:0] oldest_q;
	logic [1:0]                status_q;
	logic [rvr_pkg::OCC_W-1:0] occ_out_q;

	logic          match;
	logic          live;
	logic          is_newest;
	logic          is_tail;
	logic          full;
	logic          last_step;
	logic          pop_now;
	logic [IW-1:0] occ_inc;
	logic [IW-1:0] occ_dec;

	assign occ_inc   = IW'(occ_q + 1'b1);
	assign occ_dec   = IW'(occ_q - 1'b1);
	assign match     = head_entry.version == ver_q;
	assign live      = step_q < occ_q;
	assign is_newest = (occ_q != '0) && (step_q == occ_dec);
	assign is_tail   = step_q == occ_q;
	assign full      = occ_q == IW'(RING_DEPTH - 1);
	assign last_step = step_q == IW'(RING_DEPTH - 1);
	// oldest entry released by its last reader
	assign pop_now   = (state_q == S_SCAN) && (op_q == rvr_pkg::OP_RELEASE) &&
	                   (step_q == '0) && live && match &&
	                   (head_entry.count == rvr_pkg::CNT_W'(1));

	always_comb begin
		ctrl.shift = 1'b0;
		ctrl.feed  = head_entry;
		unique case (state_q)
			S_SCAN: begin
				ctrl.shift = 1'b1;
				if (op_q == rvr_pkg::OP_ACQUIRE) begin
					if (is_newest && match) begin
						if (head_entry.count != '1) begin
							ctrl.feed.count = head_entry.count + rvr_pkg::CNT_W'(1);
						end
					end else if (is_tail && !found_q && !full) begin
						ctrl.feed.version = ver_q;
						ctrl.feed.count   = rvr_pkg::CNT_W'(1);
					end
				end else if (!pop_now && live && match && !found_q &&
				             head_entry.count != '0) begin
					ctrl.feed.count = head_entry.count - rvr_pkg::CNT_W'(1);
				end
			end
			// drop following entries that no reader holds
			S_POP: ctrl.shift = (occ_q != '0) && (head_entry.count == '0);
			default: ctrl.shift = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= rvr_pkg::OP_QUERY;
			ver_q     <= '0;
			step_q    <= '0;
			occ_q     <= '0;
			found_q   <= 1'b0;
			app_q     <= 1'b0;
			done_q    <= 1'b0;
			oldest_q  <= '0;
			status_q  <= rvr_pkg::ST_OK;
			occ_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						ver_q   <= version;
						step_q  <= '0;
						found_q <= 1'b0;
						app_q   <= 1'b0;
						unique case (opcode)
							rvr_pkg::OP_ACQUIRE,
							rvr_pkg::OP_RELEASE: state_q <= S_SCAN;
							default: begin
								done_q    <= 1'b1;
								oldest_q  <= (occ_q != '0) ? head_entry.version : version;
								status_q  <= rvr_pkg::ST_OK;
								occ_out_q <= rvr_pkg::OCC_W'(occ_q);
							end
						endcase
					end
				end
				S_SCAN: begin
					step_q <= IW'(step_q + 1'b1);
					if (pop_now) begin
						occ_q   <= occ_dec;
						found_q <= 1'b1;
						state_q <= S_POP;
					end else begin
						if (op_q == rvr_pkg::OP_ACQUIRE) begin
							if (is_newest && match) begin
								found_q <= 1'b1;
							end else if (is_tail && !found_q && !full) begin
								found_q <= 1'b1;
								app_q   <= 1'b1;
							end
						end else if (live && match) begin
							found_q <= 1'b1;
						end
						if (last_step) begin
							state_q <= S_FIN;
						end
					end
				end
				S_POP: begin
					if (ctrl.shift) begin
						occ_q <= occ_dec;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// ring is back in line: cell 0 holds the oldest entry
					if (app_q) begin
						occ_q <= occ_inc;
					end
					done_q    <= 1'b1;
					oldest_q  <= (occ_q != '0 || app_q) ? head_entry.version : ver_q;
					occ_out_q <= rvr_pkg::OCC_W'(app_q ? occ_inc : occ_q);
					if (found_q) begin
						status_q <= rvr_pkg::ST_OK;
					end else if (op_q == rvr_pkg::OP_ACQUIRE) begin
						status_q <= rvr_pkg::ST_FULL;
					end else begin
						status_q <= rvr_pkg::ST_NOT_FOUND;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy           = state_q != S_IDLE;
	assign done           = done_q;
	assign oldest_version = oldest_q;
	assign status         = status_q;
	assign occupancy      = occ_out_q;

endmodule

FILE: sv/reader_version_refcount_ring_core.sv
// ----------------------------------------------------------------------------
// reader_version_refcount_ring_core
// Reader version reference-count ring: a rotating chain of entry cells with a
// sequencer at cell 0 that acquires, releases and reports the oldest version.
// ----------------------------------------------------------------------------
// Query: result strobe the cycle after the transfer; busy stays low throughout.
// Acquire and release: the chain rotates RING_DEPTH cells past cell 0 in S_SCAN,
//   then S_FIN registers the result. A release that pops leaves S_SCAN early;
//   S_POP drops the zero-count entries, then S_FIN. One command in flight at a time.
// Reset clears occupancy and sequencer at once; entry cells are not cleared.
// The receiver cannot stall: done is high for exactly one cycle per result.
module reader_version_refcount_ring_core #(
	parameter int RING_DEPTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  opcode,
	input  logic [rvr_pkg::VER_W-1:0]   version,
	output logic                        done,
	output logic [rvr_pkg::VER_W-1:0]   oldest_version,
	output logic [1:0]                  status,
	output logic [rvr_pkg::OCC_W-1:0]   occupancy
);

	rvr_pkg::entry_t      cell_q [RING_DEPTH];
	rvr_pkg::chain_ctrl_t ctrl;

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		rvr_pkg::entry_t d;
		if (i == RING_DEPTH - 1) begin : g_far
			assign d = ctrl.feed;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		rvr_cell u_cell (
			.clk   (clk),
			.shift (ctrl.shift),
			.d     (d),
			.q     (cell_q[i])
		);
	end

	rvr_head #(
		.RING_DEPTH (RING_DEPTH)
	) u_head (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.opcode         (opcode),
		.version        (version),
		.head_entry     (cell_q[0]),
		.busy           (busy),
		.ctrl           (ctrl),
		.done           (done),
		.oldest_version (oldest_version),
		.status         (status),
		.occupancy      (occupancy)
	);

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the reader version ring: directed command sequences, then
// random acquire/release/query traffic. An in-bench ring model predicts each
// result at the command transfer; results are checked in order as they strobe.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RING_DEPTH = 32;
	localparam logic [1:0] OP_SPARE = 2'd3;	// unused code, behaves as a query

	typedef struct {
		logic [rvr_pkg::VER_W-1:0] oldest;
		logic [1:0]                st;
		logic [rvr_pkg::OCC_W-1:0] occ;
	} ring_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [1:0]                opcode;
	logic [rvr_pkg::VER_W-1:0] version;
	logic                      done;
	logic [rvr_pkg::VER_W-1:0] oldest_version;
	logic [1:0]                status;
	logic [rvr_pkg::OCC_W-1:0] occupancy;

	// ring model
	logic [rvr_pkg::VER_W-1:0] ring_ver [RING_DEPTH];
	logic [rvr_pkg::CNT_W-1:0] ring_cnt [RING_DEPTH];
	int unsigned               head_idx;
	int unsigned               tail_idx;

	ring_result_t pending_results [$];
	int unsigned  err_count;
	bit           steady_run;

	reader_version_refcount_ring_core #(.RING_DEPTH(RING_DEPTH)) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.version        (version),
		.done           (done),
		.oldest_version (oldest_version),
		.status         (status),
		.occupancy      (occupancy)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("reader_version_refcount_ring_core regression: fail");
		$finish;
	end

	function automatic int unsigned ring_live();
		return (tail_idx + RING_DEPTH - head_idx) % RING_DEPTH;
	endfunction

	function automatic logic [rvr_pkg::VER_W-1:0] newest_ver();
		return ring_ver[(tail_idx + RING_DEPTH - 1) % RING_DEPTH];
	endfunction

	// applies one command to the model and returns the result it should give
	function automatic ring_result_t ring_update(logic [1:0] op,
	                                             logic [rvr_pkg::VER_W-1:0] ver);
		ring_result_t res;
		int unsigned  last;
		int unsigned  pos;
		bit           found;
		res.st = rvr_pkg::ST_OK;
		last   = (tail_idx + RING_DEPTH - 1) % RING_DEPTH;
		pos    = head_idx;
		found  = 1'b0;
		if (op == rvr_pkg::OP_ACQUIRE) begin
			if (ring_live() != 0 && ring_ver[last] == ver) begin
				if (ring_cnt[last] != '1)
					ring_cnt[last] = ring_cnt[last] + 1;
			end else if (ring_live() >= RING_DEPTH - 1) begin
				res.st = rvr_pkg::ST_FULL;
			end else begin
				ring_ver[tail_idx] = ver;
				ring_cnt[tail_idx] = 1;
				tail_idx = (tail_idx + 1) % RING_DEPTH;
			end
		end else if (op == rvr_pkg::OP_RELEASE) begin
			while (pos != tail_idx && !found) begin
				if (ring_ver[pos] == ver)
					found = 1'b1;
				else
					pos = (pos + 1) % RING_DEPTH;
			end
			if (!found) begin
				res.st = rvr_pkg::ST_NOT_FOUND;
			end else if (pos == head_idx && ring_cnt[pos] == 1) begin
				// pop the head, then any run of released entries behind it
				head_idx = (head_idx + 1) % RING_DEPTH;
				while (head_idx != tail_idx && ring_cnt[head_idx] == 0)
					head_idx = (head_idx + 1) % RING_DEPTH;
			end else if (ring_cnt[pos] != 0) begin
				ring_cnt[pos] = ring_cnt[pos] - 1;
			end
		end
		res.oldest = (head_idx != tail_idx) ? ring_ver[head_idx] : ver;
		res.occ    = rvr_pkg::OCC_W'(ring_live());
		return res;
	endfunction

	task automatic send_cmd(input logic [1:0] op, input logic [rvr_pkg::VER_W-1:0] ver);
		bit hold;
		@(negedge clk);
		opcode  <= op;
		version <= ver;
		forever begin
			hold = !steady_run && ($urandom_range(99) < 13);
			start <= !hold;
			@(posedge clk);
			if (!hold && !busy)
				break;
			@(negedge clk);
		end
		pending_results.push_back(ring_update(op, ver));
	endtask

	function automatic logic [rvr_pkg::VER_W-1:0] rand_ver();
		return {$urandom, $urandom};
	endfunction

	task automatic test_basic_ops();
		send_cmd(rvr_pkg::OP_QUERY, '0);
		send_cmd(OP_SPARE, '1);
		send_cmd(rvr_pkg::OP_RELEASE, 64'd5);		// empty ring, not found
		send_cmd(rvr_pkg::OP_ACQUIRE, '1);
		send_cmd(rvr_pkg::OP_ACQUIRE, '1);		// bump newest
		send_cmd(rvr_pkg::OP_ACQUIRE, '0);
		send_cmd(rvr_pkg::OP_QUERY, 64'h0123_4567_89ab_cdef);
		send_cmd(rvr_pkg::OP_RELEASE, '1);
		send_cmd(rvr_pkg::OP_RELEASE, '1);		// head at one: pop
		send_cmd(rvr_pkg::OP_RELEASE, 64'd7);		// not found with entries live
		send_cmd(rvr_pkg::OP_RELEASE, '0);
	endtask

	task automatic test_zero_count_release();
		logic [rvr_pkg::VER_W-1:0] va;
		logic [rvr_pkg::VER_W-1:0] vb;
		logic [rvr_pkg::VER_W-1:0] vc;
		va = rand_ver();
		vb = ~va;
		vc = va ^ 64'h8000_0000_0000_0001;
		send_cmd(rvr_pkg::OP_ACQUIRE, va);
		send_cmd(rvr_pkg::OP_ACQUIRE, vb);
		send_cmd(rvr_pkg::OP_ACQUIRE, va);		// same version, new entry
		send_cmd(rvr_pkg::OP_ACQUIRE, vc);
		send_cmd(rvr_pkg::OP_RELEASE, vb);		// middle entry down to zero
		send_cmd(rvr_pkg::OP_RELEASE, vb);		// stays at zero
		send_cmd(rvr_pkg::OP_RELEASE, va);		// first match: pops head and zeroed entry
		send_cmd(rvr_pkg::OP_RELEASE, vc);
		send_cmd(rvr_pkg::OP_RELEASE, va);		// pops the rest
	endtask

	task automatic test_full_ring();
		logic [rvr_pkg::VER_W-1:0] vers [RING_DEPTH-1];
		for (int i = 0; i < RING_DEPTH - 1; i++) begin
			vers[i] = {$urandom, 32'(i)};
			send_cmd(rvr_pkg::OP_ACQUIRE, vers[i]);
		end
		send_cmd(rvr_pkg::OP_ACQUIRE, ~vers[0]);		// append dropped
		send_cmd(rvr_pkg::OP_ACQUIRE, vers[RING_DEPTH-2]);	// bump still allowed
		send_cmd(rvr_pkg::OP_RELEASE, vers[RING_DEPTH-2]);
		for (int i = RING_DEPTH - 2; i > 0; i--)
			send_cmd(rvr_pkg::OP_RELEASE, vers[i]);
		send_cmd(rvr_pkg::OP_RELEASE, vers[0]);		// pops the whole ring
	endtask

	task automatic test_random_traffic(int unsigned n_items);
		logic [rvr_pkg::VER_W-1:0] pool [8];
		logic [rvr_pkg::VER_W-1:0] ver;
		int unsigned               acq_pct;
		int unsigned               r;
		int unsigned               live;
		acq_pct = 50;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i % 150 == 0) begin
				foreach (pool[k])
					pool[k] = rand_ver();
				acq_pct = $urandom_range(35, 75);
			end
			steady_run = (i >= 500 && i < 800);
			live = ring_live();
			r = $urandom_range(99);
			if (r < acq_pct) begin
				if (live != 0 && $urandom_range(99) < 35)
					ver = newest_ver();
				else if ($urandom_range(99) < 10)
					ver = rand_ver();
				else
					ver = pool[$urandom_range(7)];
				send_cmd(rvr_pkg::OP_ACQUIRE, ver);
			end else if (r < 96) begin
				if (live != 0 && $urandom_range(99) < 50)
					ver = ring_ver[head_idx];
				else if (live != 0 && $urandom_range(99) < 75)
					ver = ring_ver[(head_idx + $urandom_range(live - 1)) % RING_DEPTH];
				else if ($urandom_range(1))
					ver = pool[$urandom_range(7)];
				else
					ver = rand_ver();
				send_cmd(rvr_pkg::OP_RELEASE, ver);
			end else begin
				send_cmd($urandom_range(1) ? rvr_pkg::OP_QUERY : OP_SPARE, rand_ver());
			end
		end
		steady_run = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		ring_result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: oldest_version %h status %0d occupancy %0d",
					oldest_version, status, occupancy);
				err_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (oldest_version !== exp_res.oldest) begin
					$error("oldest_version: expected %h, got %h", exp_res.oldest, oldest_version);
					err_count++;
				end
				if (status !== exp_res.st) begin
					$error("status: expected %0d, got %0d", exp_res.st, status);
					err_count++;
				end
				if (occupancy !== exp_res.occ) begin
					$error("occupancy: expected %0d, got %0d", exp_res.occ, occupancy);
					err_count++;
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		opcode     = rvr_pkg::OP_QUERY;
		version    = '0;
		steady_run = 1'b0;
		err_count  = 0;
		head_idx   = 0;
		tail_idx   = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_zero_count_release();
		test_full_ring();
		test_random_traffic(1350);

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// catch any stray result strobe after the last expected one
		repeat (RING_DEPTH + 8) @(posedge clk);

		if (err_count == 0)
			$display("reader_version_refcount_ring_core regression: pass");
		else
			$display("reader_version_refcount_ring_core regression: fail");
		$finish;
	end

endmodule
